[hw/rtl/cbm_pkg.sv]
`default_nettype none

package cbm_pkg;

  localparam int unsigned LANES      = 8;
  localparam int unsigned LANE_W     = 3;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned CFG_SIZE_W = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned SUM_W      = 33;

  localparam logic [7:0] FILL_BYTE = 8'h57;

  localparam logic [CFG_IDX_W-1:0]  REG_MEMORY_BYTES_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_CHECK_ENABLE        = 2'd1;
  localparam logic [CFG_SIZE_W-1:0] SIZE_RESET              = 17'd65536;

  typedef enum logic [0:0] {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    ST_OK      = 1'b0,
    ST_INVALID = 1'b1
  } status_e;

  typedef struct packed {
    op_e                operation;
    logic [ADDR_W-1:0]  byte_address;
    logic [COUNT_W-1:0] byte_count;
    logic [DATA_W-1:0]  write_bytes;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_bytes;
    status_e           access_status;
  } out_item_t;

  // decoded access, per-lane view
  typedef struct packed {
    logic               ok;
    logic               wr_op;
    logic [LANES-1:0]   lane_en;
    logic [LANE_W-1:0]  offset;
    logic [COUNT_W-1:0] count;
  } access_t;

endpackage

`default_nettype wire

[hw/rtl/cbm_ram.sv]
`default_nettype none

module cbm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/cbm_init.sv]
`default_nettype none

module cbm_init #(
  parameter int unsigned ROWS  = 8192,
  parameter int unsigned ROW_W = 13
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  output logic                  busy_o,
  output logic      [ROW_W-1:0] row_o
);

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  logic             busy_q, busy_d;
  logic [ROW_W-1:0] row_q, row_d;

  always_comb begin
    busy_d = busy_q;
    row_d  = row_q;
    if (busy_q) begin
      if (row_q == LAST_ROW) begin
        busy_d = 1'b0;
      end else begin
        row_d = row_q + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      row_q  <= '0;
    end else begin
      busy_q <= busy_d;
      row_q  <= row_d;
    end
  end

  assign busy_o = busy_q;
  assign row_o  = row_q;

endmodule

`default_nettype wire

[hw/rtl/cbm_lane_ctrl.sv]
`default_nettype none

module cbm_lane_ctrl import cbm_pkg::*; #(
  parameter int unsigned STORE_BYTES      = 65536,
  parameter int unsigned MAX_ACCESS_BYTES = 8,
  parameter int unsigned ROW_W            = 13
) (
  input  wire in_item_t              item_i,
  input  wire logic [CFG_SIZE_W-1:0] size_i,
  output access_t                    acc_o,
  output logic      [ROW_W-1:0]      base_row_o
);

  localparam logic [SUM_W-1:0]   STORE_LIMIT = SUM_W'(STORE_BYTES);
  localparam logic [COUNT_W-1:0] MAX_COUNT   = COUNT_W'(MAX_ACCESS_BYTES);

  logic [SUM_W-1:0]  limit;
  logic [SUM_W-1:0]  end_addr;
  logic [LANE_W-1:0] offset;
  logic [LANE_W-1:0] idx;

  always_comb begin
    limit    = (SUM_W'(size_i) > STORE_LIMIT) ? STORE_LIMIT : SUM_W'(size_i);
    end_addr = SUM_W'(item_i.byte_address) + SUM_W'(item_i.byte_count);
    offset   = item_i.byte_address[LANE_W-1:0];

    acc_o.ok       = (item_i.byte_count != '0) && (item_i.byte_count <= MAX_COUNT)
                     && (end_addr <= limit);
    acc_o.wr_op    = (item_i.operation == OP_WRITE);
    acc_o.offset   = offset;
    acc_o.count    = item_i.byte_count;
    idx            = '0;
    for (int b = 0; b < LANES; b++) begin
      // byte position that lands in lane b
      idx              = LANE_W'(b) - offset;
      acc_o.lane_en[b] = (COUNT_W'(idx) < item_i.byte_count);
    end
  end

  assign base_row_o = item_i.byte_address[ROW_W+LANE_W-1:LANE_W];

endmodule

`default_nettype wire

[hw/rtl/checked_byte_memory.sv]
`default_nettype none

// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+------------------------
// in       | input     | in_valid_i/in_stall_o   | in_data_i  (in_item_t)
// out      | output    | out_valid_o/out_stall_i | out_data_o (out_item_t)
// cfg      | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// one access per cycle while in_stall_o is low; the result is registered
// in the synchronous lane memories, then in the result register
// eight byte lanes, each a data memory and a mark memory of STORE_BYTES/8 rows
// after reset the lanes are swept once, one row per cycle, with input
// stalled meanwhile
// an output stall holds the result register and backs up through the read stage

module checked_byte_memory import cbm_pkg::*; #(
  parameter int unsigned STORE_BYTES      = 65536,
  parameter int unsigned MAX_ACCESS_BYTES = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_SIZE_W-1:0] cfg_data_i
);

  localparam int unsigned ROWS  = (STORE_BYTES + LANES - 1) / LANES;
  localparam int unsigned ROW_W = $clog2(ROWS);

  logic [CFG_SIZE_W-1:0] size_q;
  logic                  check_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= SIZE_RESET;
      check_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MEMORY_BYTES_IN_USE: size_q  <= cfg_data_i;
        REG_CHECK_ENABLE:        check_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic             init_busy;
  logic [ROW_W-1:0] init_row;

  cbm_init #(
    .ROWS  (ROWS),
    .ROW_W (ROW_W)
  ) u_init (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .busy_o (init_busy),
    .row_o  (init_row)
  );

  access_t          acc;
  logic [ROW_W-1:0] base_row;

  cbm_lane_ctrl #(
    .STORE_BYTES      (STORE_BYTES),
    .MAX_ACCESS_BYTES (MAX_ACCESS_BYTES),
    .ROW_W            (ROW_W)
  ) u_lane_ctrl (
    .item_i     (in_data_i),
    .size_i     (size_q),
    .acc_o      (acc),
    .base_row_o (base_row)
  );

  logic      s1_valid_q, s1_valid_d;
  access_t   s1_acc_q;
  logic      s1_adv;
  logic      in_accept;
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q;
  out_item_t result;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = init_busy || (s1_valid_q && !s1_adv);
  assign in_accept  = in_valid_i && !in_stall_o;

  logic [LANES-1:0][7:0] lane_data;
  logic [LANES-1:0]      lane_mark;

  for (genvar b = 0; b < LANES; b++) begin : g_lane
    logic [ROW_W-1:0]  lane_row;
    logic [LANE_W-1:0] pos;
    logic              wr_hit;
    logic              data_we;
    logic              mark_we;
    logic [ROW_W-1:0]  waddr;
    logic [7:0]        wbyte;

    assign lane_row = base_row + ROW_W'(LANE_W'(b) < acc.offset);
    assign pos      = LANE_W'(b) - acc.offset;
    assign wr_hit   = in_accept && acc.ok && acc.wr_op && acc.lane_en[b];
    assign data_we  = init_busy || wr_hit;
    assign mark_we  = init_busy || (wr_hit && check_q);
    assign waddr    = init_busy ? init_row : lane_row;
    assign wbyte    = init_busy ? FILL_BYTE : in_data_i.write_bytes[{pos, 3'b000} +: 8];

    cbm_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_data_ram (
      .clk_i   (clk_i),
      .we_i    (data_we),
      .waddr_i (waddr),
      .wdata_i (wbyte),
      .re_i    (in_accept),
      .raddr_i (lane_row),
      .rdata_o (lane_data[b])
    );

    cbm_ram #(
      .WIDTH (1),
      .DEPTH (ROWS)
    ) u_mark_ram (
      .clk_i   (clk_i),
      .we_i    (mark_we),
      .waddr_i (waddr),
      .wdata_i (!init_busy),
      .re_i    (in_accept),
      .raddr_i (lane_row),
      .rdata_o (lane_mark[b])
    );
  end

  // realign lanes into byte order and check marks
  logic [DATA_W-1:0] rd_bytes;
  logic              uninit;
  logic              invalid;
  logic [LANE_W-1:0] src_lane;

  always_comb begin
    rd_bytes = '0;
    uninit   = 1'b0;
    src_lane = '0;
    for (int i = 0; i < LANES; i++) begin
      src_lane = LANE_W'(i) + s1_acc_q.offset;
      if (COUNT_W'(i) < s1_acc_q.count) begin
        rd_bytes[8*i +: 8] = lane_data[src_lane];
      end
      if (s1_acc_q.lane_en[i] && !lane_mark[i]) begin
        uninit = 1'b1;
      end
    end
    invalid = !s1_acc_q.ok || (!s1_acc_q.wr_op && check_q && uninit);
    result.access_status = invalid ? ST_INVALID : ST_OK;
    result.read_bytes    = (!s1_acc_q.wr_op && !invalid) ? rd_bytes : '0;
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_valid_q && s1_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_acc_q <= acc;
    end
    if (s1_valid_q && s1_adv) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire
